[rtl/frame_peak_agc_assert.svh]
// Assertion macros for the frame peak AGC block.
// Included by the RTL modules that carry concurrent checks; no other dependency.
`ifndef FRAME_PEAK_AGC_ASSERT_SVH
`define FRAME_PEAK_AGC_ASSERT_SVH

`ifndef ASSERT_OFF
// Property holds on every cycle outside reset.
`define FPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("frame_peak_agc assertion failed");
// Antecedent implies consequent on the same cycle.
`define FPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame_peak_agc assertion failed");
// Antecedent implies consequent on the next cycle.
`define FPA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame_peak_agc assertion failed");
`else
`define FPA_ASSERT(lbl, clk, rst, prop)
`define FPA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FPA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/fpa_pkg.sv]
// Package for the frame peak AGC: widths, reset values, register indexes, types.
// No dependencies; used by fpa_div and frame_peak_agc.
`default_nettype none

package fpa_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int QUO_W        = SAMPLE_W;        // top bit flags overflow
   localparam int STEP_CNT_W   = $clog2(QUO_W);
   localparam int CSR_IDX_W    = 2;

   localparam int FRAME_LENGTH_DEF = 256;

   localparam logic [SAMPLE_W-1:0] MIDSCALE       = 12'd2048;
   localparam logic [SAMPLE_W-1:0] GOAL_LEVEL_RST = 12'd1800;
   localparam logic [SAMPLE_W-1:0] START_PEAK_RST = 12'd1800;
   localparam logic [SAMPLE_W-1:0] GATE_LEVEL_RST = 12'd300;
   localparam logic [SAMPLE_W-1:0] DAC_MAX        = 12'd4095;
   localparam logic [SAMPLE_W-1:0] DAC_MIN        = 12'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GOAL_LEVEL = 2'd0,
      CSR_START_PEAK = 2'd1,
      CSR_GATE_LEVEL = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } agc_state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic ovf;
   } div_status_type;

endpackage

`default_nettype wire

[rtl/fpa_div.sv]
// Shared restoring divider, one quotient bit per cycle, for the AGC gain.
// Depends on fpa_pkg and frame_peak_agc_assert.svh.
`default_nettype none

module fpa_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fpa_pkg::div_ctrl_type          ctrl,
   input  wire logic [fpa_pkg::PROD_W-1:0]     dividend,
   input  wire logic [fpa_pkg::SAMPLE_W-1:0]   divisor,
   output      fpa_pkg::div_status_type        status,
   output      logic [fpa_pkg::QUO_W-2:0]      quotient
);

   localparam int DSH_W = fpa_pkg::SAMPLE_W + fpa_pkg::QUO_W - 1;
   localparam logic [fpa_pkg::STEP_CNT_W-1:0] LAST_STEP =
      fpa_pkg::STEP_CNT_W'(fpa_pkg::QUO_W - 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [fpa_pkg::STEP_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [fpa_pkg::PROD_W-1:0]        rem_ff, rem_in;
   logic [DSH_W-1:0]                  dsh_ff, dsh_in;
   logic [fpa_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [fpa_pkg::SAMPLE_W-1:0]      div_nz;
   logic                              fits;

   // zero divisor only meets a zero dividend; treat it as one
   assign div_nz = (divisor == '0) ? fpa_pkg::SAMPLE_W'(1) : divisor;
   assign fits   = rem_ff >= fpa_pkg::PROD_W'(dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (ctrl.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dsh_in  = {div_nz, {(fpa_pkg::QUO_W-1){1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - fpa_pkg::PROD_W'(dsh_ff);
         end
         quo_in = {quo_ff[fpa_pkg::QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   // quotient bit 11 set means q >= 2048: saturate
   assign status   = {busy_ff, done_ff, quo_ff[fpa_pkg::QUO_W-1]};
   assign quotient = quo_ff[fpa_pkg::QUO_W-2:0];

   `include "frame_peak_agc_assert.svh"

   `FPA_ASSERT_IMP(a_start_when_free, clock, reset, ctrl.start, !busy_ff)
   `FPA_ASSERT_NXT(a_start_busy, clock, reset, ctrl.start, busy_ff)
   `FPA_ASSERT_IMP(a_done_not_busy, clock, reset, done_ff, !busy_ff)

endmodule

`default_nettype wire

[rtl/frame_peak_agc.sv]
// Path from req beat to rsp_valid: a bypassed sample goes through the multiply state, done
// and the result register; a scaled one through multiply, divider load, 12 divider steps,
// done and result register. A new beat is taken only after the last one has left ST_DONE.
// req_ready is high only while the sequencer is idle; csr_ready is always high.
// Reset: synchronous, active high; registers to 1800/1800/300, peak to 1800, frame
// position to zero, no result pending. Depends on fpa_pkg, fpa_div and the assert header.
`default_nettype none

module frame_peak_agc #(
   parameter int FRAME_LENGTH = fpa_pkg::FRAME_LENGTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample in
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [fpa_pkg::SAMPLE_W-1:0]      req_adc_sample,
   // sample out
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [fpa_pkg::SAMPLE_W-1:0]      rsp_dac_sample,
   output      logic                              rsp_frame_last,
   // register writes
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [fpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fpa_pkg::SAMPLE_W-1:0]      csr_data
);

   localparam int IDX_W = (FRAME_LENGTH > 1) ? $clog2(FRAME_LENGTH) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LENGTH - 1);

   // config registers
   logic [fpa_pkg::SAMPLE_W-1:0] goal_ff, start_ff, gate_ff;

   // sequencer and per-beat working registers
   fpa_pkg::agc_state_type        state_ff, state_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [fpa_pkg::SAMPLE_W-1:0]  peak_ff, peak_in;
   logic [fpa_pkg::SAMPLE_W-1:0]  code_ff, code_in;
   logic [fpa_pkg::SAMPLE_W-1:0]  mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic                          gated_ff, gated_in;
   logic                          last_ff, last_in;
   logic [fpa_pkg::PROD_W-1:0]    prod_ff, prod_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fpa_pkg::SAMPLE_W-1:0]  dac_ff, dac_in;
   logic                          flast_ff, flast_in;

   fpa_pkg::div_ctrl_type         div_ctrl;
   fpa_pkg::div_status_type       div_sts;
   logic [fpa_pkg::QUO_W-2:0]     div_quo;

   logic                          req_fire, rsp_fire, slot_free;
   logic [fpa_pkg::SAMPLE_W-1:0]  in_mag, peak_base, dac_scaled;
   logic                          in_neg, in_gated;

   assign req_ready = (state_ff == fpa_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ----------------------------------------------------------------------
   // Register file: user must write only while no beat is in flight; not enforced here.
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff  <= fpa_pkg::GOAL_LEVEL_RST;
         start_ff <= fpa_pkg::START_PEAK_RST;
         gate_ff  <= fpa_pkg::GATE_LEVEL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fpa_pkg::CSR_GOAL_LEVEL: goal_ff  <= csr_data;
            fpa_pkg::CSR_START_PEAK: start_ff <= csr_data;
            fpa_pkg::CSR_GATE_LEVEL: gate_ff  <= csr_data;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ----------------------------------------------------------------------
   // Input decode: strip midscale, magnitude 0..2048 fits 12 bits.
   // ----------------------------------------------------------------------
   assign in_neg   = !req_adc_sample[fpa_pkg::SAMPLE_W-1];
   assign in_mag   = in_neg ? (fpa_pkg::MIDSCALE - req_adc_sample)
                            : (req_adc_sample - fpa_pkg::MIDSCALE);
   assign in_gated = in_mag >= gate_ff;
   // peak restarts at the first sample of each frame
   assign peak_base = (idx_ff == '0) ? start_ff : peak_ff;

   // Scaled result: positive -> 2048 + q, negative -> 2048 - q, saturating.
   always_comb begin
      if (neg_ff) begin
         dac_scaled = div_sts.ovf ? fpa_pkg::DAC_MIN
                                  : fpa_pkg::MIDSCALE - fpa_pkg::SAMPLE_W'(div_quo);
      end else begin
         dac_scaled = div_sts.ovf ? fpa_pkg::DAC_MAX : {1'b1, div_quo};
      end
   end

   // ----------------------------------------------------------------------
   // Sequencer
   // ----------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      peak_in      = peak_ff;
      code_in      = code_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      gated_in     = gated_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      dac_in       = dac_ff;
      flast_in     = flast_ff;
      div_ctrl     = '0;

      unique case (state_ff)
         fpa_pkg::ST_IDLE: begin
            if (req_fire) begin
               code_in  = req_adc_sample;
               mag_in   = in_mag;
               neg_in   = in_neg;
               gated_in = in_gated;
               last_in  = (idx_ff == IDX_LAST);
               idx_in   = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
               peak_in  = (in_gated && (in_mag > peak_base)) ? in_mag : peak_base;
               state_in = fpa_pkg::ST_MULT;
            end
         end
         fpa_pkg::ST_MULT: begin
            // single 12x12 product, registered before the divider sees it
            prod_in  = fpa_pkg::PROD_W'(mag_ff) * fpa_pkg::PROD_W'(goal_ff);
            state_in = gated_ff ? fpa_pkg::ST_DIV : fpa_pkg::ST_DONE;
            div_ctrl.start = 1'b0;
         end
         fpa_pkg::ST_DIV: begin
            // first cycle here kicks the divider, then wait for its done pulse
            div_ctrl.start = !div_sts.busy && !div_sts.done;
            if (div_sts.done) begin
               state_in = fpa_pkg::ST_DONE;
            end
         end
         fpa_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               dac_in       = gated_ff ? dac_scaled : code_ff;
               flast_in     = last_ff;
               state_in     = fpa_pkg::ST_IDLE;
            end
         end
         default: state_in = fpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpa_pkg::ST_IDLE;
         idx_ff       <= '0;
         peak_ff      <= fpa_pkg::START_PEAK_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff  <= code_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      gated_ff <= gated_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      dac_ff   <= dac_in;
      flast_ff <= flast_in;
   end

   // shared divider: product over running peak
   fpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod_ff),
      .divisor  (peak_ff),
      .status   (div_sts),
      .quotient (div_quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dac_sample = dac_ff;
   assign rsp_frame_last = flast_ff;

   `include "frame_peak_agc_assert.svh"

   `FPA_ASSERT_NXT(a_accept_to_mult, clock, reset, req_fire, state_ff == fpa_pkg::ST_MULT)
   `FPA_ASSERT_IMP(a_div_owned, clock, reset, div_sts.busy || div_sts.done,
                   state_ff == fpa_pkg::ST_DIV)
   `FPA_ASSERT_NXT(a_done_loads_rsp, clock, reset,
                   state_ff == fpa_pkg::ST_DONE && slot_free, rsp_valid_ff)
   `FPA_ASSERT(a_idx_in_frame, clock, reset, idx_ff <= IDX_LAST)

endmodule

`default_nettype wire
